@@ hdl/psfrl_pkg.sv @@
// psfrl_pkg: shared widths, register indexes and table entry types
// for the per-source forward rate limiter; no dependencies
`default_nettype none

package psfrl_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int MAC_W = 48;
   localparam int LEN_W = 8;
   localparam int BYTE_W = 8;
   localparam int TIME_W = 32;
   localparam int IVL_W = 24;
   localparam int SLOT_W = 4;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [3:0] LOCATION_TYPE = 4'h1;

   localparam logic [CSR_IDX_W-1:0] CSR_DYN_IVL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STA_IVL = CSR_IDX_W'(1);

   localparam logic [IVL_W-1:0] DYN_IVL_RESET = IVL_W'(1000);
   localparam logic [IVL_W-1:0] STA_IVL_RESET = IVL_W'(10000);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [TIME_W-1:0] last_dyn;
      logic [TIME_W-1:0] last_sta;
   } entry_type;

   typedef struct packed {
      logic      en;
      idx_type   addr;
      entry_type entry;
   } tbl_wr_type;

endpackage

`default_nettype wire

@@ hdl/psfrl_if.sv @@
// psfrl_if: valid/ready channel interfaces for packet requests,
// decisions and register writes; depends on psfrl_pkg
`default_nettype none

interface psfrl_req_if import psfrl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MAC_W-1:0]  src_addr;
   logic              is_pack;
   logic [LEN_W-1:0]  payload_len;
   logic [BYTE_W-1:0] first_byte;
   logic [TIME_W-1:0] now_ms;

   modport source(output valid, src_addr, is_pack, payload_len, first_byte, now_ms,
                  input ready);
   modport sink(input valid, src_addr, is_pack, payload_len, first_byte, now_ms,
                output ready);
endinterface

interface psfrl_rsp_if import psfrl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              forward;
   logic              dynamic_class;
   logic              table_hit;
   logic [SLOT_W-1:0] slot_index;

   modport source(output valid, forward, dynamic_class, table_hit, slot_index,
                  input ready);
   modport sink(input valid, forward, dynamic_class, table_hit, slot_index,
                output ready);
endinterface

interface psfrl_csr_if import psfrl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/per_source_forward_rate_limiter.sv @@
// per_source_forward_rate_limiter: takes a new packet only when idle; each packet
// goes through accept, a scan with one table read and compare per entry (the compare
// works on the registered read), then update; a hit stops the scan early. the result
// waits in an output register while the next packet is taken, and update stalls
// until that register is free. reset clears the valid bits at once and restores both
// intervals; depends on psfrl_pkg, psfrl_if, psfrl_table
`default_nettype none

module per_source_forward_rate_limiter import psfrl_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   psfrl_req_if.sink   req_chan,
   psfrl_rsp_if.source rsp_chan,
   psfrl_csr_if.sink   csr_chan
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   idx_type           scan_ff, scan_in;
   logic              issued_ff, issued_in;
   logic              cmp_vld_ff, cmp_vld_in;
   idx_type           cmp_idx_ff;
   logic              have_free_ff, have_free_in;
   idx_type           free_ff, free_in;
   idx_type           oldest_ff, oldest_in;
   logic [TIME_W-1:0] oldest_t_ff, oldest_t_in;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [IVL_W-1:0]  dyn_ivl_ff, sta_ivl_ff;

   logic [MAC_W-1:0]  mac_ff;
   logic              dyn_ff;
   logic [TIME_W-1:0] now_ff;
   idx_type           slot_ff, slot_in;
   logic              hit_ff, hit_in;
   logic [TIME_W-1:0] base_dyn_ff, base_dyn_in;
   logic [TIME_W-1:0] base_sta_ff, base_sta_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_fwd_ff;
   logic              rsp_dyn_ff;
   logic              rsp_hit_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   entry_type         rd_entry;
   tbl_wr_type        tbl_wr;

   logic              req_xfer;
   logic              rsp_free;
   logic              pkt_dyn;
   logic              cur_valid;
   logic              cur_hit;
   logic [TIME_W-1:0] cur_recent;
   logic              nf_have;
   idx_type           nf_idx;
   idx_type           no_idx;
   logic [TIME_W-1:0] no_t;
   logic [TIME_W-1:0] cls_last;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] cls_ivl;
   logic              fwd;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   psfrl_table u_table (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd_addr  (scan_ff),
      .rd_entry (rd_entry)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign pkt_dyn = req_chan.is_pack ||
                    ((req_chan.payload_len != '0) && (req_chan.first_byte[7:4] == LOCATION_TYPE));

   // current scan entry against the running free and oldest picks
   always_comb begin
      cur_valid = valid_ff[cmp_idx_ff];
      cur_hit = cur_valid && (rd_entry.mac == mac_ff);
      if (!cur_valid) begin
         cur_recent = '0;
      end else if (rd_entry.last_dyn > rd_entry.last_sta) begin
         cur_recent = rd_entry.last_dyn;
      end else begin
         cur_recent = rd_entry.last_sta;
      end
      nf_have = have_free_ff || !cur_valid;
      nf_idx = (!have_free_ff && !cur_valid) ? cmp_idx_ff : free_ff;
      if (cur_recent < oldest_t_ff) begin
         no_idx = cmp_idx_ff;
         no_t = cur_recent;
      end else begin
         no_idx = oldest_ff;
         no_t = oldest_t_ff;
      end
   end

   // rate check for the class of the packet
   always_comb begin
      cls_last = dyn_ff ? base_dyn_ff : base_sta_ff;
      elapsed = now_ff - cls_last;
      cls_ivl = {{(TIME_W-IVL_W){1'b0}}, dyn_ff ? dyn_ivl_ff : sta_ivl_ff};
      fwd = (elapsed >= cls_ivl);
   end

   always_comb begin
      tbl_wr.en = (state_ff == ST_UPDATE) && rsp_free;
      tbl_wr.addr = slot_ff;
      tbl_wr.entry.mac = mac_ff;
      tbl_wr.entry.last_dyn = (fwd && dyn_ff) ? now_ff : base_dyn_ff;
      tbl_wr.entry.last_sta = (fwd && !dyn_ff) ? now_ff : base_sta_ff;
   end

   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      issued_in = issued_ff;
      cmp_vld_in = 1'b0;
      have_free_in = have_free_ff;
      free_in = free_ff;
      oldest_in = oldest_ff;
      oldest_t_in = oldest_t_ff;
      slot_in = slot_ff;
      hit_in = hit_ff;
      base_dyn_in = base_dyn_ff;
      base_sta_in = base_sta_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SCAN;
               scan_in = '0;
               issued_in = 1'b0;
               have_free_in = 1'b0;
               free_in = '0;
               oldest_in = '0;
               oldest_t_in = '1;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = !issued_ff;
            if (!issued_ff) begin
               if (scan_ff == LAST_IDX) begin
                  issued_in = 1'b1;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            if (cmp_vld_ff) begin
               if (cur_hit) begin
                  state_in = ST_UPDATE;
                  slot_in = cmp_idx_ff;
                  hit_in = 1'b1;
                  base_dyn_in = rd_entry.last_dyn;
                  base_sta_in = rd_entry.last_sta;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  state_in = ST_UPDATE;
                  slot_in = nf_have ? nf_idx : no_idx;
                  hit_in = 1'b0;
                  base_dyn_in = '0;
                  base_sta_in = '0;
               end else begin
                  have_free_in = nf_have;
                  free_in = nf_idx;
                  oldest_in = no_idx;
                  oldest_t_in = no_t;
               end
            end
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issued_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff <= '0;
         dyn_ivl_ff <= DYN_IVL_RESET;
         sta_ivl_ff <= STA_IVL_RESET;
      end else begin
         state_ff <= state_in;
         issued_ff <= issued_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tbl_wr.en) begin
            valid_ff[slot_ff] <= 1'b1;
         end
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_DYN_IVL: dyn_ivl_ff <= csr_chan.data[IVL_W-1:0];
               CSR_STA_IVL: sta_ivl_ff <= csr_chan.data[IVL_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign slot_ext = {{SLOT_W{1'b0}}, slot_ff};

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      cmp_idx_ff <= scan_ff;
      have_free_ff <= have_free_in;
      free_ff <= free_in;
      oldest_ff <= oldest_in;
      oldest_t_ff <= oldest_t_in;
      slot_ff <= slot_in;
      hit_ff <= hit_in;
      base_dyn_ff <= base_dyn_in;
      base_sta_ff <= base_sta_in;
      if (req_xfer) begin
         mac_ff <= req_chan.src_addr;
         dyn_ff <= pkt_dyn;
         now_ff <= req_chan.now_ms;
      end
      if (tbl_wr.en) begin
         rsp_fwd_ff <= fwd;
         rsp_dyn_ff <= dyn_ff;
         rsp_hit_ff <= hit_ff;
         rsp_slot_ff <= slot_ext[SLOT_W-1:0];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.forward = rsp_fwd_ff;
   assign rsp_chan.dynamic_class = rsp_dyn_ff;
   assign rsp_chan.table_hit = rsp_hit_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;

endmodule

`default_nettype wire

@@ hdl/psfrl_table.sv @@
// psfrl_table: transmitter table memory, one write port and one
// registered read port; depends on psfrl_pkg
`default_nettype none

module psfrl_table import psfrl_pkg::*; (
   input  wire logic       clock,
   input  wire tbl_wr_type wr,
   input  wire idx_type    rd_addr,
   output entry_type       rd_entry
);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

@@ tb/psfrl_tb_pkg.sv @@
`timescale 1ns / 100ps
// psfrl_tb_pkg: packet and decision records, plus a mirror of the source table
// and both intervals that predicts each forward decision; depends on psfrl_pkg
package psfrl_tb_pkg;
   import psfrl_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = CSR_IDX_W'(2);

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic              is_pack;
      logic [LEN_W-1:0]  payload_len;
      logic [BYTE_W-1:0] first_byte;
      logic [TIME_W-1:0] now_ms;
   } packet_type;

   typedef struct packed {
      logic              forward;
      logic              dynamic_class;
      logic              table_hit;
      logic [SLOT_W-1:0] slot_index;
   } decision_type;

   class limiter_mirror;
      logic [IVL_W-1:0]  dyn_ivl;
      logic [IVL_W-1:0]  sta_ivl;
      bit                slot_used [TABLE_ENTRIES];
      logic [MAC_W-1:0]  slot_mac [TABLE_ENTRIES];
      logic [TIME_W-1:0] slot_dyn [TABLE_ENTRIES];
      logic [TIME_W-1:0] slot_sta [TABLE_ENTRIES];
      decision_type      pending_decisions [$];
      int                errors;

      function new();
         dyn_ivl = DYN_IVL_RESET;
         sta_ivl = STA_IVL_RESET;
         errors = 0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_dyn[i] = '0;
            slot_sta[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_DYN_IVL: dyn_ivl = data[IVL_W-1:0];
            CSR_STA_IVL: sta_ivl = data[IVL_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_packet(packet_type p);
         logic              dyn;
         logic              hit;
         logic              fwd;
         logic              have_free;
         int                slot;
         int                free_idx;
         int                oldest_idx;
         logic [TIME_W-1:0] oldest_time;
         logic [TIME_W-1:0] recent;
         logic [TIME_W-1:0] elapsed;
         decision_type      d;
         dyn = p.is_pack || (p.payload_len != '0 && p.first_byte[7:4] == LOCATION_TYPE);
         hit = 1'b0;
         slot = 0;
         have_free = 1'b0;
         free_idx = 0;
         oldest_idx = 0;
         oldest_time = '1;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!hit) begin
               if (slot_used[i] && slot_mac[i] == p.mac) begin
                  hit = 1'b1;
                  slot = i;
               end else begin
                  if (!slot_used[i] && !have_free) begin
                     have_free = 1'b1;
                     free_idx = i;
                  end
                  recent = (slot_dyn[i] > slot_sta[i]) ? slot_dyn[i] : slot_sta[i];
                  if (recent < oldest_time) begin
                     oldest_time = recent;
                     oldest_idx = i;
                  end
               end
            end
         end
         if (!hit) begin
            slot = have_free ? free_idx : oldest_idx;
            slot_used[slot] = 1'b1;
            slot_mac[slot] = p.mac;
            slot_dyn[slot] = '0;
            slot_sta[slot] = '0;
         end
         if (dyn) begin
            elapsed = p.now_ms - slot_dyn[slot];
            fwd = elapsed >= TIME_W'(dyn_ivl);
            if (fwd) slot_dyn[slot] = p.now_ms;
         end else begin
            elapsed = p.now_ms - slot_sta[slot];
            fwd = elapsed >= TIME_W'(sta_ivl);
            if (fwd) slot_sta[slot] = p.now_ms;
         end
         d.forward = fwd;
         d.dynamic_class = dyn;
         d.table_hit = hit;
         d.slot_index = SLOT_W'(slot);
         pending_decisions.push_back(d);
      endfunction

      function void check_decision(decision_type got);
         decision_type want;
         if (pending_decisions.size() == 0) begin
            $display("%0t: decision with nothing expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_decisions.pop_front();
         if (got.forward !== want.forward) begin
            $display("%0t: forward expected %0b actual %0b", $time, want.forward, got.forward);
            errors++;
         end
         if (got.dynamic_class !== want.dynamic_class) begin
            $display("%0t: dynamic_class expected %0b actual %0b", $time,
                     want.dynamic_class, got.dynamic_class);
            errors++;
         end
         if (got.table_hit !== want.table_hit) begin
            $display("%0t: table_hit expected %0b actual %0b", $time,
                     want.table_hit, got.table_hit);
            errors++;
         end
         if (got.slot_index !== want.slot_index) begin
            $display("%0t: slot_index expected %0d actual %0d", $time,
                     want.slot_index, got.slot_index);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_decisions.size();
      endfunction
   endclass

endpackage

@@ tb/tb_per_source_forward_rate_limiter.sv @@
`timescale 1ns / 100ps
// tb_per_source_forward_rate_limiter: drives packets and interval writes into the
// rate limiter and checks every decision; depends on psfrl_pkg, psfrl_if, psfrl_tb_pkg
module tb_per_source_forward_rate_limiter;
   import psfrl_pkg::*;
   import psfrl_tb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 123;
   localparam int POOL_MAX = 28;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psfrl_req_if req_chan ();
   psfrl_rsp_if rsp_chan ();
   psfrl_csr_if csr_chan ();

   limiter_mirror mirror = new();

   int unsigned       cycles = 0;
   bit                calm = 1'b0;
   logic [TIME_W-1:0] now_base = '0;
   logic [MAC_W-1:0]  mac_pool [POOL_MAX];
   int                pool_size = 1;

   per_source_forward_rate_limiter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic packet_type make_packet(logic [MAC_W-1:0] mac, logic pack,
                                              logic [LEN_W-1:0] len, logic [BYTE_W-1:0] fb,
                                              logic [TIME_W-1:0] now);
      packet_type p;
      p.mac = mac;
      p.is_pack = pack;
      p.payload_len = len;
      p.first_byte = fb;
      p.now_ms = now;
      return p;
   endfunction

   function automatic logic [IVL_W-1:0] pick_interval();
      int r;
      r = $urandom_range(0, 5);
      case (r)
         0: return '0;
         1: return '1;
         2, 3: return IVL_W'($urandom_range(1, 300));
         4: return IVL_W'($urandom_range(1, 5000));
         default: return IVL_W'($urandom);
      endcase
   endfunction

   function automatic void fill_pool();
      pool_size = $urandom_range(3, POOL_MAX);
      for (int i = 0; i < POOL_MAX; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) mac_pool[0] = '1;
      if ($urandom_range(0, 3) == 0) mac_pool[1] = '0;
   endfunction

   function automatic packet_type random_packet();
      packet_type p;
      int r;
      r = $urandom_range(0, 15);
      p.mac = (r == 0) ? MAC_W'({$urandom, $urandom})
                       : mac_pool[$urandom_range(0, pool_size - 1)];
      p.is_pack = ($urandom_range(0, 3) == 0);
      p.payload_len = ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom);
      p.first_byte = $urandom_range(0, 1) ? {LOCATION_TYPE, 4'($urandom)} : BYTE_W'($urandom);
      r = $urandom_range(0, 39);
      if (r == 0) now_base = TIME_W'($urandom);
      else if (r == 1) now_base = 32'hFFFF_FF00 + TIME_W'($urandom_range(0, 255));
      else now_base = now_base + TIME_W'($urandom_range(0, 400));
      p.now_ms = now_base;
      return p;
   endfunction

   task automatic send_packet(input packet_type p);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.src_addr <= p.mac;
      req_chan.is_pack <= p.is_pack;
      req_chan.payload_len <= p.payload_len;
      req_chan.first_byte <= p.first_byte;
      req_chan.now_ms <= p.now_ms;
      do @(posedge clock); while (!req_chan.ready);
      mirror.take_packet(p);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= data;
      do @(posedge clock); while (!csr_chan.ready);
      mirror.write_reg(index, data);
   endtask

   // upper data bits are random so masking gets exercised
   task automatic set_intervals(input logic [IVL_W-1:0] dyn, input logic [IVL_W-1:0] sta,
                                input bit stray);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[IVL_W-1:0] = dyn;
      write_reg(CSR_DYN_IVL, word);
      word = $urandom;
      word[IVL_W-1:0] = sta;
      write_reg(CSR_STA_IVL, word);
      if (stray) write_reg(CSR_NO_REG, $urandom);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (mirror.outstanding() > 0) @(posedge clock);
   endtask

   // decision side
   initial begin
      int stall;
      decision_type got;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.forward = rsp_chan.forward;
         got.dynamic_class = rsp_chan.dynamic_class;
         got.table_hit = rsp_chan.table_hit;
         got.slot_index = rsp_chan.slot_index;
         mirror.check_decision(got);
      end
   end

   initial begin
      logic [MAC_W-1:0] mac_a;
      mac_a = 48'h0012_3456_789A;
      req_chan.valid <= 1'b0;
      req_chan.src_addr <= '0;
      req_chan.is_pack <= 1'b0;
      req_chan.payload_len <= '0;
      req_chan.first_byte <= '0;
      req_chan.now_ms <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= '0;
      csr_chan.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset intervals: empty payload, pack, location nibble, other nibble, wrap
      send_packet(make_packet(mac_a, 1'b0, 8'd0, 8'h1F, 32'd0));
      send_packet(make_packet(mac_a, 1'b1, 8'd0, 8'h00, 32'd1000));
      send_packet(make_packet(mac_a, 1'b0, 8'd1, 8'h10, 32'd1999));
      send_packet(make_packet(mac_a, 1'b0, 8'd255, 8'hFF, 32'd10000));
      send_packet(make_packet(mac_a, 1'b0, 8'd8, 8'h2F, 32'd20000));
      send_packet(make_packet('1, 1'b0, 8'd1, 8'h1F, 32'hFFFF_FFFF));
      send_packet(make_packet('1, 1'b1, 8'd0, 8'h00, 32'd5));
      send_packet(make_packet('1, 1'b1, 8'd0, 8'h00, 32'd1004));
      send_packet(make_packet('0, 1'b0, 8'd0, 8'h10, 32'h8000_0000));
      // fill the table, then force an eviction
      for (int i = 3; i < TABLE_ENTRIES + 2; i++)
         send_packet(make_packet(48'h5A5A_0000_0000 + MAC_W'(i), i[0], 8'd4, 8'h15,
                                 32'h0000_2000 + TIME_W'(i * 700)));
      drain();
      set_intervals('0, '0, 1'b0);
      send_packet(make_packet(mac_a, 1'b1, 8'd0, 8'h00, 32'd3));
      send_packet(make_packet(mac_a, 1'b0, 8'd2, 8'h30, 32'd3));
      drain();
      set_intervals('1, '1, 1'b1);
      send_packet(make_packet('1, 1'b1, 8'd0, 8'h00, 32'h0100_0000));
      send_packet(make_packet('1, 1'b0, 8'd0, 8'h00, 32'h00FF_FFFF));
      send_packet(make_packet(48'hA5A5_A5A5_A5A5, 1'b0, 8'd0, 8'h00, 32'h00FF_FFFE));

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         calm = (ph % 3 == 2);
         set_intervals(pick_interval(), pick_interval(), $urandom_range(0, 3) == 0);
         fill_pool();
         repeat (PHASE_ITEMS) send_packet(random_packet());
      end

      drain();
      repeat (40) @(posedge clock);
      if (mirror.errors == 0 && mirror.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
